### design/ktlu_pkg.sv
// Shared constants, types and helpers for the keyed sensor table.
// No dependencies; used by keyed_table_lru_upsert.
`timescale 1ns / 1ps
`default_nettype none

package ktlu_pkg;

   // Table geometry
   localparam int SLOTS  = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // Field widths
   localparam int PROTO_W   = 8;
   localparam int ID_W      = 32;
   localparam int CHAN_W    = 8;
   localparam int TEMP_W    = 16;
   localparam int HUM_W     = 8;
   localparam int BATT_W    = 2;
   localparam int TS_W      = 32;
   localparam int KEY_W     = PROTO_W + ID_W + CHAN_W;
   localparam int PAYLOAD_W = TEMP_W + HUM_W + BATT_W;

   // Result field widths
   localparam int OUT_SLOT_W = 3;
   localparam int OUT_CNT_W  = 4;

   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [PAYLOAD_W-1:0] payload_type;
   typedef logic [TS_W-1:0]      ts_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [CNT_W-1:0]     count_type;

   // Wrap-safe age test: a is older than b when (a - b) is negative
   function automatic logic older_than(input ts_type a, input ts_type b);
      ts_type diff;
      diff = a - b;
      return diff[TS_W-1];
   endfunction

endpackage

`default_nettype wire

### design/keyed_table_lru_upsert.sv
// Fully associative sensor table with key update, free fill and oldest-entry replacement.
// Depends on ktlu_pkg for geometry, types and the age compare.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/req_stall| key, payload and current tick count
//   rsp_    | out       | rsp_valid/rsp_stall| slot, hit, eviction flag, occupancy
//
// Each word passes through capture, a scan of every entry through the shared key and
// age compare unit, and a write of the chosen entry.
// Reset (synchronous) clears all entry valid bits, the occupancy count and the output valid bit.
// req_stall is high while a word is in work; a waiting result does not block capture,
// but the write cycle holds until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module keyed_table_lru_upsert (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ktlu_pkg::PROTO_W-1:0]    req_protocol_code,
   input  wire logic [ktlu_pkg::ID_W-1:0]       req_sensor_id,
   input  wire logic [ktlu_pkg::CHAN_W-1:0]     req_channel_code,
   input  wire logic [ktlu_pkg::TEMP_W-1:0]     req_temperature_word,
   input  wire logic [ktlu_pkg::HUM_W-1:0]      req_humidity_value,
   input  wire logic [ktlu_pkg::BATT_W-1:0]     req_battery_status,
   input  wire logic [ktlu_pkg::TS_W-1:0]       req_now_ticks,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ktlu_pkg::OUT_SLOT_W-1:0]      rsp_slot_index,
   output logic                                 rsp_key_hit,
   output logic                                 rsp_evicted_used,
   output logic [ktlu_pkg::OUT_CNT_W-1:0]       rsp_occupied_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   // Table storage
   logic [ktlu_pkg::SLOTS-1:0] valid_ff;
   ktlu_pkg::key_type          key_mem_ff     [ktlu_pkg::SLOTS];
   ktlu_pkg::payload_type      payload_mem_ff [ktlu_pkg::SLOTS];
   ktlu_pkg::ts_type           ts_mem_ff      [ktlu_pkg::SLOTS];

   // Sequencer and captured word
   state_type                state_ff, state_in;
   ktlu_pkg::key_type        req_key_ff, req_key_in;
   ktlu_pkg::payload_type    req_payload_ff, req_payload_in;
   ktlu_pkg::ts_type         req_ts_ff, req_ts_in;
   ktlu_pkg::slot_type       scan_ff, scan_in;
   logic                     hit_found_ff, hit_found_in;
   ktlu_pkg::slot_type       hit_slot_ff, hit_slot_in;
   logic                     free_found_ff, free_found_in;
   ktlu_pkg::slot_type       free_slot_ff, free_slot_in;
   ktlu_pkg::slot_type       oldest_slot_ff, oldest_slot_in;
   ktlu_pkg::ts_type         oldest_ts_ff, oldest_ts_in;
   ktlu_pkg::count_type      count_ff, count_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   ktlu_pkg::slot_type       rsp_slot_ff, rsp_slot_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_evict_ff, rsp_evict_in;
   ktlu_pkg::count_type      rsp_count_ff, rsp_count_in;

   // Shared compare unit inputs and write port
   ktlu_pkg::key_type        key_rd;
   ktlu_pkg::ts_type         ts_rd;
   logic                     valid_rd;
   logic                     key_match;
   logic                     wr_en;
   ktlu_pkg::slot_type       wr_slot;
   logic                     scan_last;

   // Read the entry under the scan pointer
   assign key_rd    = key_mem_ff[scan_ff];
   assign ts_rd     = ts_mem_ff[scan_ff];
   assign valid_rd  = valid_ff[scan_ff];
   assign key_match = valid_rd && (key_rd == req_key_ff);
   assign scan_last = (scan_ff == ktlu_pkg::SLOT_W'(ktlu_pkg::SLOTS - 1));

   // Sequence capture, scan and write
   always_comb begin
      state_in       = state_ff;
      req_key_in     = req_key_ff;
      req_payload_in = req_payload_ff;
      req_ts_in      = req_ts_ff;
      scan_in        = scan_ff;
      hit_found_in   = hit_found_ff;
      hit_slot_in    = hit_slot_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      oldest_slot_in = oldest_slot_ff;
      oldest_ts_in   = oldest_ts_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_slot_in    = rsp_slot_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evict_in   = rsp_evict_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_slot        = hit_found_ff ? hit_slot_ff :
                       (free_found_ff ? free_slot_ff : oldest_slot_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_key_in     = {req_protocol_code, req_sensor_id, req_channel_code};
               req_payload_in = {req_temperature_word, req_humidity_value,
                                 req_battery_status};
               req_ts_in      = req_now_ticks;
               scan_in        = '0;
               hit_found_in   = 1'b0;
               free_found_in  = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // first matching entry wins
            if (!hit_found_ff && key_match) begin
               hit_found_in = 1'b1;
               hit_slot_in  = scan_ff;
            end
            // first free entry wins
            if (!free_found_ff && !valid_rd) begin
               free_found_in = 1'b1;
               free_slot_in  = scan_ff;
            end
            // seed the oldest mark at entry 0, then move it only on a strictly older entry
            if (scan_ff == '0) begin
               oldest_slot_in = scan_ff;
               oldest_ts_in   = ts_rd;
            end else if (ktlu_pkg::older_than(ts_rd, oldest_ts_ff)) begin
               oldest_slot_in = scan_ff;
               oldest_ts_in   = ts_rd;
            end
            if (scan_last) begin
               state_in = ST_WRITE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            // hold until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = wr_slot;
               rsp_hit_in   = hit_found_ff;
               rsp_evict_in = !hit_found_ff && !free_found_ff;
               if (!hit_found_ff && free_found_ff) begin
                  count_in = count_ff + ktlu_pkg::CNT_W'(1);
               end
               rsp_count_in = count_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
      req_key_ff     <= req_key_in;
      req_payload_ff <= req_payload_in;
      req_ts_ff      <= req_ts_in;
      scan_ff        <= scan_in;
      hit_slot_ff    <= hit_slot_in;
      free_slot_ff   <= free_slot_in;
      oldest_slot_ff <= oldest_slot_in;
      oldest_ts_ff   <= oldest_ts_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evict_ff   <= rsp_evict_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // Entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_slot] <= 1'b1;
      end
   end

   // Entry contents; an entry's contents take effect only after it has been written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_slot]     <= req_key_ff;
         payload_mem_ff[wr_slot] <= req_payload_ff;
         ts_mem_ff[wr_slot]      <= req_ts_ff;
      end
   end

   // Drive the ports
   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_index     = ktlu_pkg::OUT_SLOT_W'(rsp_slot_ff);
   assign rsp_key_hit        = rsp_hit_ff;
   assign rsp_evicted_used   = rsp_evict_ff;
   assign rsp_occupied_count = ktlu_pkg::OUT_CNT_W'(rsp_count_ff);

endmodule

`default_nettype wire
